// File: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types and constants for the integer to ascii formatter
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int FIELD_W = 7;
  localparam logic [6:0] LIMIT_WP = 7'd64;

  // two banks of 64 digits, one filled while the other is read out
  localparam int DIG_DEPTH = 128;

  localparam int FL_ZERO  = 0;
  localparam int FL_SIGN  = 1;
  localparam int FL_PLUS  = 2;
  localparam int FL_SPACE = 3;
  localparam int FL_LEFT  = 4;
  localparam int FL_PFX   = 5;
  localparam int FL_UPPER = 6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LEAD,
    ST_SIGN,
    ST_PFX0,
    ST_PFX1,
    ST_FILL,
    ST_DIGS
  } be_state_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_t;

  // pad counts lead, fill and trail are 8 bits wide, zeros and cap 7 bits
  typedef struct packed {
    logic              valid_radix;
    logic [7:0]        sign_ch;
    logic              has_sign;
    logic [1:0]        pfx_len;
    logic              upper;
    logic              left;
    logic              zero;
    logic [7:0]        lead;
    logic [7:0]        fill;
    logic [7:0]        trail;
    logic [6:0]        zeros;
    logic [6:0]        cap;
    logic              bank;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
    logic [7:0] c;
    if (d < 6'd10) c = CH_ZERO + {2'b00, d};
    else if (upper) c = 8'h41 + {2'b00, d} - 8'd10;
    else c = 8'h61 + {2'b00, d} - 8'd10;
    return c;
  endfunction

endpackage

// File: rtl/itoa_if.sv
// ----------------------------------------------------------------------------
// itoa_in_if / itoa_out_if
// valid/ready channels of the formatter
// ----------------------------------------------------------------------------
interface itoa_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [5:0]  radix;
  logic [6:0]  field_width;
  logic [6:0]  min_digits;
  logic [6:0]  space_left;
  logic [6:0]  flags;
  modport source (output valid, value, radix, field_width, min_digits, space_left, flags,
                  input ready);
  modport sink (input valid, value, radix, field_width, min_digits, space_left, flags,
                output ready);
endinterface

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       last;
  modport source (output valid, out_char, has_char, last, input ready);
  modport sink (input valid, out_char, has_char, last, output ready);
endinterface

// File: rtl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// sequence: accept, bit-serial division for each digit, hand-over of the job, then
// back-end states that emit pad, sign, prefix, zero fill, digits and trailing pad
// throughput: next item is divided while the previous one is emitted, one word
// per cycle at most, longer under output stalls
// reset: synchronous active low, clears control state only, digit ram kept
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int MAX_OUT    = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  itoa_in_if.sink    in_ch,
  itoa_out_if.source out_ch
);
  import itoa_pkg::*;

  logic       dig_we;
  logic [6:0] dig_waddr, dig_raddr;
  logic [5:0] dig_wdata, dig_rdata;
  logic       job_valid, job_ready;
  job_t       job_q;
  logic [6:0] job_nd;

  itoa_front #(.MAX_OUT(MAX_OUT), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst_n, .in_ch,
    .dig_we, .dig_waddr, .dig_wdata,
    .job_valid, .job_ready, .job(job_q), .job_nd
  );

  itoa_ram #(.WIDTH(6), .DEPTH(DIG_DEPTH)) u_ram (
    .clk, .we(dig_we), .waddr(dig_waddr), .wdata(dig_wdata),
    .raddr(dig_raddr), .rdata(dig_rdata)
  );

  itoa_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job(job_q), .job_nd,
    .dig_raddr, .dig_rdata, .out_ch
  );

endmodule

// File: rtl/itoa_ram.sv
// ----------------------------------------------------------------------------
// itoa_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front
// classifies an item, divides the magnitude down bit-serially and stores digits
// ----------------------------------------------------------------------------
module itoa_front #(
  parameter int MAX_OUT    = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  itoa_in_if.sink        in_ch,
  output logic           dig_we,
  output logic [6:0]     dig_waddr,
  output logic [5:0]     dig_wdata,
  output logic           job_valid,
  input  logic           job_ready,
  output itoa_pkg::job_t job,
  output logic [6:0]     job_nd
);
  import itoa_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);

  fe_state_t                 st_r, st_nxt;
  logic [VALUE_BITS-1:0]     q_r;
  logic [5:0]                rem_r;
  logic [CW-1:0]             bit_r;
  logic [5:0]                radix_r;
  logic [6:0]                nd_r;
  logic [7:0]                width_r;
  logic [6:0]                prec_r;
  logic [6:0]                cap_r;
  logic [6:0]                flags_r;
  logic                      has_sign_r;
  logic [7:0]                sign_ch_r;
  logic                      bank_r;

  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [6:0]            fl;
  logic [6:0]            rem_sh;
  logic                  ge;
  logic [6:0]            rem_new;
  logic [VALUE_BITS-1:0] q_new;
  logic [6:0]            prec_eff;
  logic [1:0]            pfx_len;
  logic signed [8:0]     wleft;
  logic [7:0]            wpad;

  assign in_ch.ready = (st_r == FE_IDLE);

  always_comb begin
    fl = in_ch.flags;
    if (fl[FL_LEFT]) fl[FL_ZERO] = 1'b0;
    neg = fl[FL_SIGN] & in_ch.value[VALUE_BITS-1];
    mag = neg ? (~in_ch.value[VALUE_BITS-1:0] + 1'b1) : in_ch.value[VALUE_BITS-1:0];
  end

  // restoring division one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, q_r[VALUE_BITS-1]};
    ge      = rem_sh >= {1'b0, radix_r};
    rem_new = ge ? rem_sh - {1'b0, radix_r} : rem_sh;
    q_new   = {q_r[VALUE_BITS-2:0], ge};
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FE_IDLE: if (in_ch.valid) st_nxt = FE_DIV;
      FE_DIV:  if (bit_r == CW'(VALUE_BITS - 1) && (q_new == '0 || nd_r == 7'd63))
                 st_nxt = FE_PUSH;
      FE_PUSH: if (job_ready) st_nxt = FE_IDLE;
      default: st_nxt = FE_IDLE;
    endcase
  end

  // digit bank flips each time a job is handed over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= FE_IDLE;
      bank_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (job_valid && job_ready) bank_r <= ~bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == FE_IDLE && in_ch.valid) begin
      q_r     <= mag;
      rem_r   <= '0;
      bit_r   <= '0;
      nd_r    <= '0;
      radix_r <= in_ch.radix;
      width_r <= (in_ch.field_width > LIMIT_WP) ? 8'd64 : {1'b0, in_ch.field_width};
      prec_r  <= (in_ch.min_digits > LIMIT_WP) ? LIMIT_WP : in_ch.min_digits;
      cap_r   <= in_ch.space_left;
      flags_r <= fl;
      has_sign_r <= fl[FL_SIGN] & (neg | fl[FL_PLUS] | fl[FL_SPACE]);
      sign_ch_r  <= neg ? CH_MINUS : (fl[FL_PLUS] ? CH_PLUS : CH_SPACE);
    end else if (st_r == FE_DIV) begin
      if (bit_r == CW'(VALUE_BITS - 1)) begin
        q_r   <= q_new;
        rem_r <= '0;
        bit_r <= '0;
        nd_r  <= nd_r + 7'd1;
      end else begin
        q_r   <= q_new;
        rem_r <= rem_new[5:0];
        bit_r <= bit_r + 1'b1;
      end
    end
  end

  assign dig_we    = (st_r == FE_DIV) && bit_r == CW'(VALUE_BITS - 1);
  assign dig_waddr = {bank_r, nd_r[5:0]};
  assign dig_wdata = rem_new[5:0];

  always_comb begin
    prec_eff = (nd_r > prec_r) ? nd_r : prec_r;
    pfx_len  = !flags_r[FL_PFX] ? 2'd0 :
               (radix_r == 6'd16) ? 2'd2 : (radix_r == 6'd8) ? 2'd1 : 2'd0;
    wleft = $signed({1'b0, width_r}) - $signed({8'b0, has_sign_r})
          - $signed({7'b0, pfx_len}) - $signed({2'b0, prec_eff});
    wpad  = wleft[8] ? 8'd0 : wleft[7:0];
  end

  always_comb begin
    job = '0;
    job.valid_radix = radix_r >= 6'd2 && radix_r <= 6'd36;
    job.sign_ch     = sign_ch_r;
    job.has_sign    = has_sign_r;
    job.pfx_len     = pfx_len;
    job.upper       = flags_r[FL_UPPER];
    job.left        = flags_r[FL_LEFT];
    job.zero        = flags_r[FL_ZERO];
    job.lead        = (!flags_r[FL_LEFT] && !flags_r[FL_ZERO]) ? wpad : 8'd0;
    job.fill        = (!flags_r[FL_LEFT] && flags_r[FL_ZERO]) ? wpad : 8'd0;
    job.trail       = flags_r[FL_LEFT] ? wpad : 8'd0;
    job.zeros       = prec_eff - nd_r;
    job.cap         = (cap_r > 7'(MAX_OUT)) ? 7'(MAX_OUT) : cap_r;
    job.bank        = bank_r;
  end

  assign job_valid = (st_r == FE_PUSH);
  assign job_nd    = nd_r;

endmodule

// File: rtl/itoa_back.sv
// ----------------------------------------------------------------------------
// itoa_back
// sequences the characters of one job and drives the output register
// ----------------------------------------------------------------------------
module itoa_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  itoa_pkg::job_t job,
  input  logic [6:0]     job_nd,
  output logic [6:0]     dig_raddr,
  input  logic [5:0]     dig_rdata,
  itoa_out_if.source     out_ch
);
  import itoa_pkg::*;

  be_state_t  st_r, st_nxt;
  job_t       j_r, j_nxt;
  logic [6:0] nd_r, nd_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [6:0] emitted_r, emitted_nxt;
  logic       trail_r, trail_nxt;
  logic       dig_wait_r, dig_wait_nxt;

  logic       ov_r, ov_nxt;
  logic [7:0] och_r, och_nxt;
  logic       ohas_r, ohas_nxt;
  logic       olast_r, olast_nxt;

  logic       emit;
  logic [7:0] ch;
  logic       last_piece;
  logic       room;
  logic       can_go;
  logic       done;
  logic       seg_end;
  logic       stall;
  logic       take;
  logic       empty_job;

  assign out_ch.valid    = ov_r;
  assign out_ch.out_char = och_r;
  assign out_ch.has_char = ohas_r;
  assign out_ch.last     = olast_r;

  assign can_go    = !ov_r || out_ch.ready;
  assign job_ready = (st_r == ST_IDLE) && can_go;
  assign take      = job_ready && job_valid;
  assign empty_job = !job.valid_radix || job.cap == 7'd0;
  assign dig_raddr = {j_r.bank, cnt_r[5:0]};

  // character of the current state
  always_comb begin
    room = (emitted_r + 7'd1) < j_r.cap;
    emit = 1'b0;
    ch   = CH_SPACE;
    seg_end = 1'b0;
    unique case (st_r)
      ST_LEAD: begin
        if (cnt_r != 8'd0) begin
          emit = 1'b1;
          ch = CH_SPACE;
        end
      end
      ST_SIGN: begin
        if (j_r.has_sign) begin
          emit = 1'b1;
          ch = j_r.sign_ch;
        end
      end
      ST_PFX0: begin
        if (j_r.pfx_len != 2'd0) begin
          emit = 1'b1;
          ch = CH_ZERO;
        end
      end
      ST_PFX1: begin
        if (j_r.pfx_len == 2'd2) begin
          emit = 1'b1;
          ch = j_r.upper ? 8'h58 : 8'h78;
        end
      end
      ST_FILL: begin
        if (cnt_r != 8'd0) begin
          emit = 1'b1;
          ch = CH_ZERO;
        end
      end
      ST_DIGS: begin
        emit = 1'b1;
        if (trail_r) begin
          ch = CH_SPACE;
          if (cnt_r == 8'd1) seg_end = 1'b1;
        end else begin
          ch = digit_char(dig_rdata, j_r.upper);
          if (cnt_r == 8'd0) seg_end = 1'b1;
        end
      end
      default: ;
    endcase
    // a char is final when room runs out or nothing remains after it
    last_piece = (st_r == ST_DIGS) && seg_end && (trail_r || j_r.trail == 8'd0);
    done  = emit && (last_piece || !room);
    stall = (emit && !can_go) || (st_r == ST_DIGS && dig_wait_r);
  end

  always_comb begin
    st_nxt = st_r;
    if (st_r == ST_IDLE) begin
      if (take && !empty_job) st_nxt = ST_DIV;
    end else if (!stall) begin
      if (done) begin
        st_nxt = ST_IDLE;
      end else begin
        unique case (st_r)
          ST_DIV:  st_nxt = ST_LEAD;
          ST_LEAD: if (cnt_r == 8'd0) st_nxt = ST_SIGN;
          ST_SIGN: st_nxt = ST_PFX0;
          ST_PFX0: st_nxt = ST_PFX1;
          ST_PFX1: st_nxt = ST_FILL;
          ST_FILL: if (cnt_r == 8'd0) st_nxt = ST_DIGS;
          ST_DIGS: st_nxt = ST_DIGS;
          default: st_nxt = ST_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    j_nxt        = j_r;
    nd_nxt       = nd_r;
    cnt_nxt      = cnt_r;
    emitted_nxt  = emitted_r;
    trail_nxt    = trail_r;
    dig_wait_nxt = 1'b0;
    ov_nxt       = ov_r && !out_ch.ready;
    och_nxt      = och_r;
    ohas_nxt     = ohas_r;
    olast_nxt    = olast_r;
    if (take) begin
      j_nxt       = job;
      nd_nxt      = job_nd;
      emitted_nxt = '0;
      trail_nxt   = 1'b0;
      if (empty_job) begin
        ov_nxt    = 1'b1;
        och_nxt   = 8'd0;
        ohas_nxt  = 1'b0;
        olast_nxt = 1'b1;
      end
    end else if (st_r != ST_IDLE && !stall) begin
      unique case (st_r)
        ST_DIV:  cnt_nxt = j_r.lead;
        ST_LEAD: if (cnt_r != 8'd0) cnt_nxt = cnt_r - 8'd1;
        ST_PFX1: cnt_nxt = j_r.fill + {1'b0, j_r.zeros};
        ST_FILL: begin
          if (cnt_r != 8'd0) begin
            cnt_nxt = cnt_r - 8'd1;
          end else begin
            cnt_nxt = {1'b0, nd_r} - 8'd1;
            dig_wait_nxt = 1'b1;
          end
        end
        ST_DIGS: begin
          if (seg_end && !trail_r) begin
            trail_nxt = 1'b1;
            cnt_nxt = j_r.trail;
          end else begin
            cnt_nxt = cnt_r - 8'd1;
            dig_wait_nxt = !trail_r;
          end
        end
        default: ;
      endcase
      if (emit) begin
        ov_nxt      = 1'b1;
        och_nxt     = ch;
        ohas_nxt    = 1'b1;
        olast_nxt   = done;
        emitted_nxt = emitted_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      ov_r       <= 1'b0;
      dig_wait_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      ov_r       <= ov_nxt;
      dig_wait_r <= dig_wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    nd_r      <= nd_nxt;
    cnt_r     <= cnt_nxt;
    emitted_r <= emitted_nxt;
    trail_r   <= trail_nxt;
    och_r     <= och_nxt;
    ohas_r    <= ohas_nxt;
    olast_r   <= olast_nxt;
  end

endmodule

// File: dv/tb_integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter
// self-checking bench for the integer to ascii formatter: directed corner
// numbers and flag combinations, then random numbers with bursty input and
// a stalling receiver, every character word checked against a local model
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic [5:0]  radix;
    logic [6:0]  field_width;
    logic [6:0]  min_digits;
    logic [6:0]  space_left;
    logic [6:0]  flags;
  } number_t;

  typedef struct {
    logic [7:0] out_char;
    logic       has_char;
    logic       last;
  } char_word_t;

  typedef logic [7:0] text_q_t[$];

  logic clk;
  logic rst_n;
  int   errors;
  int   burst_left;
  int   rdy_phase;
  int   rdy_hold;
  logic [15:0] rdy_pat;
  char_word_t expected_chars[$];

  itoa_in_if  in_ch();
  itoa_out_if out_ch();

  integer_to_ascii_formatter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #100ms;
    $display("integer_to_ascii_formatter: mismatch");
    $finish;
  end

  function automatic void put_char(ref text_q_t q, input int cap, input logic [7:0] ch);
    if (q.size() < cap) q.push_back(ch);
  endfunction

  function automatic void format_number(input number_t n, ref text_q_t q);
    logic [63:0] mag;
    logic [6:0]  fl;
    logic [7:0]  digs[$];
    logic [7:0]  fill;
    logic [7:0]  sign;
    logic [7:0]  dch;
    logic [63:0] d;
    int width, prec, cap, nd;
    q = {};
    mag = n.value;
    fl = n.flags;
    width = (n.field_width > 64) ? 64 : int'(n.field_width);
    prec = (n.min_digits > 64) ? 64 : int'(n.min_digits);
    cap = (n.space_left > 64) ? 64 : int'(n.space_left);
    sign = 8'h00;
    if (fl[FL_LEFT]) fl[FL_ZERO] = 1'b0;
    if (n.radix >= 2 && n.radix <= 36) begin
      fill = fl[FL_ZERO] ? CH_ZERO : CH_SPACE;
      if (fl[FL_SIGN]) begin
        if (mag[63]) begin
          sign = CH_MINUS;
          mag = -mag;
          width--;
        end else if (fl[FL_PLUS]) begin
          sign = CH_PLUS;
          width--;
        end else if (fl[FL_SPACE]) begin
          sign = CH_SPACE;
          width--;
        end
      end
      if (fl[FL_PFX]) begin
        if (n.radix == 16) width -= 2;
        else if (n.radix == 8) width--;
      end
      if (mag == 0) digs.push_back(CH_ZERO);
      while (mag != 0) begin
        d = mag % n.radix;
        if (d < 10) dch = CH_ZERO + d[7:0];
        else if (fl[FL_UPPER]) dch = 8'h41 + d[7:0] - 8'd10;
        else dch = 8'h61 + d[7:0] - 8'd10;
        digs.push_back(dch);
        mag = mag / n.radix;
      end
      nd = digs.size();
      if (nd > prec) prec = nd;
      width -= prec;
      if (!fl[FL_ZERO] && !fl[FL_LEFT]) begin
        for (int i = 0; i < width; i++) put_char(q, cap, CH_SPACE);
        width = 0;
      end
      if (sign != 8'h00) put_char(q, cap, sign);
      if (fl[FL_PFX] && (n.radix == 8 || n.radix == 16)) begin
        put_char(q, cap, CH_ZERO);
        if (n.radix == 16) put_char(q, cap, fl[FL_UPPER] ? 8'h58 : 8'h78);
      end
      if (!fl[FL_LEFT]) begin
        for (int i = 0; i < width; i++) put_char(q, cap, fill);
        width = 0;
      end
      for (int i = 0; i < prec - nd; i++) put_char(q, cap, CH_ZERO);
      for (int i = nd - 1; i >= 0; i--) put_char(q, cap, digs[i]);
      for (int i = 0; i < width; i++) put_char(q, cap, CH_SPACE);
    end
  endfunction

  function automatic void queue_expected(input number_t n);
    text_q_t txt;
    char_word_t w;
    format_number(n, txt);
    if (txt.size() == 0) begin
      w.out_char = 8'h00;
      w.has_char = 1'b0;
      w.last = 1'b1;
      expected_chars.push_back(w);
    end else begin
      foreach (txt[i]) begin
        w.out_char = txt[i];
        w.has_char = 1'b1;
        w.last = (i == txt.size() - 1);
        expected_chars.push_back(w);
      end
    end
  endfunction

  task automatic send_number(input number_t n);
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.value = n.value;
    in_ch.radix = n.radix;
    in_ch.field_width = n.field_width;
    in_ch.min_digits = n.min_digits;
    in_ch.space_left = n.space_left;
    in_ch.flags = n.flags;
    do @(posedge clk); while (!in_ch.ready);
    queue_expected(n);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] exp);
    errors++;
    $display("error %0t: %s got %h expected %h", $time, what, got, exp);
  endtask

  always @(negedge clk) begin
    if (rdy_hold == 0) begin
      rdy_hold = $urandom_range(50, 400);
      case ($urandom_range(0, 3))
        0: rdy_pat = 16'hffff;
        1: rdy_pat = 16'h0001 << $urandom_range(0, 15) | 16'h8000;
        default: rdy_pat = 16'($urandom) | 16'h0001;
      endcase
    end
    rdy_hold--;
    rdy_phase = (rdy_phase + 1) % 16;
    out_ch.ready = rst_n && rdy_pat[rdy_phase];
  end

  always @(posedge clk) begin
    char_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected word", out_ch.out_char, 8'h00);
      end else begin
        e = expected_chars.pop_front();
        if (out_ch.has_char !== e.has_char)
          report_mismatch("has_char", {7'd0, out_ch.has_char}, {7'd0, e.has_char});
        if (out_ch.last !== e.last)
          report_mismatch("last", {7'd0, out_ch.last}, {7'd0, e.last});
        if (e.has_char && out_ch.out_char !== e.out_char)
          report_mismatch("out_char", out_ch.out_char, e.out_char);
        if (!e.has_char && out_ch.out_char !== 8'h00)
          report_mismatch("empty out_char", out_ch.out_char, 8'h00);
      end
    end
  end

  function automatic number_t mk(input logic [63:0] v, input int r, input int w, input int p,
                                 input int s, input logic [6:0] f);
    number_t n;
    n.value = v;
    n.radix = r[5:0];
    n.field_width = w[6:0];
    n.min_digits = p[6:0];
    n.space_left = s[6:0];
    n.flags = f;
    return n;
  endfunction

  function automatic number_t random_number();
    number_t n;
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: n.value = 64'($urandom_range(0, 40));
      1: n.value = -64'($urandom_range(1, 40));
      2: n.value = 64'h8000_0000_0000_0000;
      3: n.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: n.value = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 9) == 0) n.radix = 6'($urandom_range(0, 63));
    else if ($urandom_range(0, 3) == 0) n.radix = ($urandom_range(0, 1) != 0) ? 6'd8 : 6'd16;
    else n.radix = 6'($urandom_range(3, 36));
    n.field_width = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 30));
    n.min_digits = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(0, 25));
    n.space_left = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(40, 64));
    n.flags = 7'($urandom_range(0, 127));
    return n;
  endfunction

  task automatic test_extremes();
    send_number(mk(64'd0, 10, 0, 0, 64, 7'h00));
    send_number(mk('1, 2, 0, 0, 64, 7'h00));
    send_number(mk('1, 36, 0, 0, 64, 7'h40));
    send_number(mk(64'h8000_0000_0000_0000, 10, 0, 0, 64, 7'h02));
    send_number(mk('1, 16, 8, 0, 64, 7'h63));
    send_number(mk(64'd0, 8, 4, 0, 64, 7'h20));
    send_number(mk(64'd0, 16, 6, 0, 64, 7'h21));
    send_number(mk(64'd255, 16, 10, 0, 64, 7'h61));
    send_number(mk(64'd123, 10, 127, 127, 127, 7'h00));
    send_number(mk(64'd42, 10, 64, 64, 64, 7'h10));
  endtask

  task automatic test_flag_rules();
    send_number(mk(64'd42, 10, 8, 0, 64, 7'h06));
    send_number(mk(64'd42, 10, 8, 0, 64, 7'h0a));
    send_number(mk(-64'd42, 10, 8, 4, 64, 7'h0f));
    send_number(mk(64'd42, 10, 8, 0, 64, 7'h11));
    send_number(mk(64'd42, 10, 8, 0, 64, 7'h1e));
    send_number(mk(64'd7, 7, 0, 5, 64, 7'h01));
    send_number(mk(64'd42, 10, 0, 0, 64, 7'h04));
  endtask

  task automatic test_no_output();
    send_number(mk(64'd5, 0, 4, 0, 64, 7'h00));
    send_number(mk(64'd5, 1, 4, 0, 64, 7'h00));
    send_number(mk(64'd5, 37, 4, 0, 64, 7'h00));
    send_number(mk(64'd5, 63, 4, 0, 64, 7'h7f));
    send_number(mk(64'd5, 10, 4, 0, 0, 7'h00));
    send_number(mk('1, 2, 80, 0, 3, 7'h00));
    send_number(mk(64'd1, 10, 0, 0, 1, 7'h00));
  endtask

  task automatic test_random(input int count);
    repeat (count) send_number(random_number());
  endtask

  task automatic test_drain_pause();
    test_random(10);
    wait_drained();
    test_random(10);
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    rdy_phase = 0;
    rdy_hold = 0;
    rdy_pat = 16'hffff;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.radix = '0;
    in_ch.field_width = '0;
    in_ch.min_digits = '0;
    in_ch.space_left = '0;
    in_ch.flags = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_flag_rules();
    test_no_output();
    test_random(110);
    test_drain_pause();
    test_random(120);
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("integer_to_ascii_formatter: match");
    end else begin
      $display("integer_to_ascii_formatter: mismatch");
    end
    $finish;
  end

endmodule

// File: integer_to_ascii_formatter.f
rtl/itoa_pkg.sv
rtl/itoa_if.sv
rtl/itoa_ram.sv
rtl/itoa_front.sv
rtl/itoa_back.sv
rtl/integer_to_ascii_formatter.sv
dv/tb_integer_to_ascii_formatter.sv
